>>> hdl/wildmat_list_matcher_assert.svh
// Assertion macros shared by the checker.
`ifndef WILDMAT_LIST_MATCHER_ASSERT_SVH
`define WILDMAT_LIST_MATCHER_ASSERT_SVH

// Same-cycle implication, sampled on the rising clock, off during reset.
`define WLM_ASSERT_NOW(lbl, pre, post) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (pre) |-> (post)) \
        else $error("wildmat checker: property failed");

// Next-cycle implication, sampled on the rising clock, off during reset.
`define WLM_ASSERT_NEXT(lbl, pre, post) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (pre) |=> (post)) \
        else $error("wildmat checker: property failed");

`endif

>>> hdl/wlm_pkg.sv
`timescale 1ns / 1ps

package wlm_pkg;

    localparam int unsigned BYTE_W = 8;

    typedef enum logic [1:0] {
        CMD_CLEAR  = 2'd0,
        CMD_APPEND = 2'd1,
        CMD_TEXT   = 2'd2,
        CMD_END    = 2'd3
    } t_cmd;

    // Role a cell takes after the compile pass.
    typedef enum logic [3:0] {
        R_DEAD,
        R_END,
        R_STAR,
        R_ANY,
        R_LIT,
        R_ESC,
        R_OPEN,
        R_ELIT,
        R_SKIP,
        R_MEM,
        R_RANGE,
        R_CLOSE
    } t_role;

    // Parser state handed from cell to cell during compile.
    typedef enum logic [3:0] {
        S_ITEM,
        S_ELEM,
        S_ESCD,
        S_CFIRST,
        S_CMEMF,
        S_CMEM,
        S_SKIP2,
        S_SKIP1,
        S_TAIL
    } t_sst;

    typedef struct packed {
        logic tok;
        t_sst st;
        logic ineg;
        logic cneg;
        logic pstart;
    } t_scan;

    // Per-byte chain between neighbors: token, class hit, star closures.
    typedef struct packed {
        logic tok;
        logic hit;
        logic cl;
        logic scl;
    } t_link;

    typedef struct packed {
        logic              open;
        logic              upd;
        logic              clr;
        logic [BYTE_W-1:0] c;
    } t_ctl;

    localparam logic [BYTE_W-1:0] C_STAR   = 8'h2A;
    localparam logic [BYTE_W-1:0] C_QMARK  = 8'h3F;
    localparam logic [BYTE_W-1:0] C_LBRK   = 8'h5B;
    localparam logic [BYTE_W-1:0] C_CARET  = 8'h5E;
    localparam logic [BYTE_W-1:0] C_BANG   = 8'h21;
    localparam logic [BYTE_W-1:0] C_DASH   = 8'h2D;
    localparam logic [BYTE_W-1:0] C_RBRK   = 8'h5D;
    localparam logic [BYTE_W-1:0] C_BSLASH = 8'h5C;
    localparam logic [BYTE_W-1:0] C_COMMA  = 8'h2C;

endpackage

>>> hdl/wlm_cell.sv
`timescale 1ns / 1ps

module wlm_cell (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_pat_we,
    input  logic [wlm_pkg::BYTE_W-1:0] i_pat_wdata,
    input  logic                      i_below,
    input  logic [wlm_pkg::BYTE_W-1:0] i_p1,
    input  logic [wlm_pkg::BYTE_W-1:0] i_p2,
    input  logic                      i_v1,
    input  logic                      i_v2,
    input  wlm_pkg::t_scan            i_scan,
    output wlm_pkg::t_scan            o_scan,
    input  wlm_pkg::t_link            i_link,
    output wlm_pkg::t_link            o_link,
    input  wlm_pkg::t_ctl             i_ctl,
    output logic                      o_cur,
    output logic                      o_end,
    output logic                      o_neg
);
    import wlm_pkg::*;

    logic [BYTE_W-1:0] r_pat;
    t_scan             r_scan;
    t_role             r_role;
    logic              r_flag;
    logic              r_blk;
    logic              r_start;
    logic              r_live;
    logic              r_scl;

    t_scan n_scan;
    t_role n_role;
    logic  n_flag;
    logic  n_blk;
    logic  n_start;
    logic  w_v0;
    logic  w_cur;
    logic  w_eq;
    logic  w_rng;
    logic  w_inner;
    logic  w_star;
    logic  w_nset;
    logic  w_cl;
    logic  w_scl;

    assign w_v0 = i_below && (r_pat != C_COMMA);

    // Parse this byte when the compile token sits here.
    always_comb begin
        logic do_elem;
        logic do_mem;
        logic first;
        logic is_end;
        do_elem = 1'b0;
        do_mem  = 1'b0;
        first   = 1'b0;
        is_end  = 1'b0;
        n_scan  = r_scan;
        n_scan.pstart = 1'b0;
        n_role  = R_DEAD;
        n_flag  = 1'b0;
        n_blk   = 1'b0;
        n_start = 1'b0;
        case (r_scan.st)
            S_ITEM: begin
                if (!w_v0) begin
                    is_end = 1'b1;
                end else if (r_pat == C_BANG) begin
                    n_role        = R_DEAD;
                    n_scan.st     = S_ELEM;
                    n_scan.ineg   = 1'b1;
                    n_scan.pstart = 1'b1;
                end else begin
                    n_start     = 1'b1;
                    n_scan.ineg = 1'b0;
                    do_elem     = 1'b1;
                end
            end
            S_ELEM: begin
                if (!w_v0) begin
                    is_end = 1'b1;
                end else begin
                    n_start = r_scan.pstart;
                    do_elem = 1'b1;
                end
            end
            S_ESCD: begin
                n_role    = R_ELIT;
                n_scan.st = S_ELEM;
            end
            S_CFIRST: begin
                if (!w_v0) begin
                    is_end = 1'b1;
                end else if (r_pat == C_CARET || r_pat == C_BANG) begin
                    n_role      = R_SKIP;
                    n_scan.cneg = 1'b1;
                    n_scan.st   = S_CMEMF;
                end else begin
                    n_scan.cneg = 1'b0;
                    do_mem      = 1'b1;
                    first       = 1'b1;
                end
            end
            S_CMEMF: begin
                if (!w_v0) begin
                    is_end = 1'b1;
                end else begin
                    do_mem = 1'b1;
                    first  = 1'b1;
                end
            end
            S_CMEM: begin
                if (!w_v0) begin
                    is_end = 1'b1;
                end else begin
                    do_mem = 1'b1;
                end
            end
            S_SKIP2: begin
                n_role    = R_SKIP;
                n_scan.st = S_SKIP1;
            end
            S_SKIP1: begin
                n_role    = R_SKIP;
                n_scan.st = S_CMEM;
            end
            S_TAIL: begin
                n_role = R_DEAD;
            end
            default: begin
                n_role = R_DEAD;
            end
        endcase

        if (is_end) begin
            n_role    = R_END;
            n_start   = (r_scan.st == S_ITEM) || r_scan.pstart;
            n_flag    = (r_scan.st == S_ITEM) ? 1'b0 : r_scan.ineg;
            // an item that ends inside a class never matches
            n_blk     = (r_scan.st == S_CFIRST) || (r_scan.st == S_CMEMF) ||
                        (r_scan.st == S_CMEM);
            n_scan.st = i_below ? S_ITEM : S_TAIL;
        end

        if (do_elem) begin
            n_scan.st = S_ELEM;
            case (r_pat)
                C_STAR:  n_role = R_STAR;
                C_QMARK: n_role = R_ANY;
                C_LBRK: begin
                    n_role    = R_OPEN;
                    n_scan.st = S_CFIRST;
                end
                C_BSLASH: begin
                    if (i_v1) begin
                        n_role    = R_ESC;
                        n_scan.st = S_ESCD;
                    end else begin
                        n_role = R_LIT;
                    end
                end
                default: n_role = R_LIT;
            endcase
        end

        if (do_mem) begin
            if (r_pat == C_RBRK && !first) begin
                n_role    = R_CLOSE;
                n_flag    = n_scan.cneg;
                n_scan.st = S_ELEM;
            end else if (i_v1 && i_v2 && i_p1 == C_DASH && i_p2 != C_RBRK) begin
                n_role    = R_RANGE;
                n_scan.st = S_SKIP2;
            end else begin
                n_role    = R_MEM;
                n_scan.st = S_CMEM;
            end
        end
    end

    assign o_scan = n_scan;

    // Text step: token ripple, class hit accumulation, star closure.
    always_comb begin
        w_cur   = i_ctl.open ? r_live : r_scl;
        w_eq    = (r_pat == i_ctl.c);
        w_rng   = (i_ctl.c >= r_pat) && (i_ctl.c <= i_p2);
        w_inner = r_role inside {R_ELIT, R_SKIP, R_MEM, R_RANGE, R_CLOSE};
        w_star  = (r_role == R_STAR);
        o_link.tok = 1'b0;
        o_link.hit = 1'b0;
        case (r_role)
            R_ANY:   o_link.tok = w_cur;
            R_ESC:   o_link.tok = w_cur;
            R_OPEN:  o_link.tok = w_cur;
            R_LIT:   o_link.tok = w_cur && w_eq;
            R_ELIT:  o_link.tok = i_link.tok && w_eq;
            R_SKIP: begin
                o_link.tok = i_link.tok;
                o_link.hit = i_link.hit;
            end
            R_MEM: begin
                o_link.tok = i_link.tok;
                o_link.hit = i_link.hit || w_eq;
            end
            R_RANGE: begin
                o_link.tok = i_link.tok;
                o_link.hit = i_link.hit || w_rng;
            end
            R_CLOSE: o_link.tok = i_link.tok && (i_link.hit ^ r_flag);
            default: o_link.tok = 1'b0;
        endcase
        w_nset = !w_inner &&
                 ((i_link.tok && !(r_role == R_END && r_blk)) || (w_star && w_cur));
        w_cl       = w_nset || i_link.cl;
        w_scl      = r_start || i_link.scl;
        o_link.cl  = w_cl && w_star;
        o_link.scl = w_scl && w_star;
    end

    assign o_cur = w_cur;
    assign o_end = (r_role == R_END);
    assign o_neg = r_flag;

    always_ff @(posedge i_clk) begin
        if (i_pat_we) begin
            r_pat <= i_pat_wdata;
        end
        if (r_scan.tok) begin
            r_role  <= n_role;
            r_flag  <= n_flag;
            r_blk   <= n_blk;
            r_start <= n_start;
        end
        r_scl <= w_scl;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scan <= '0;
            r_live <= 1'b0;
        end else begin
            r_scan <= i_scan;
            if (i_ctl.upd) begin
                r_live <= w_cl;
            end else if (i_ctl.clr) begin
                r_live <= 1'b0;
            end
        end
    end

endmodule

>>> hdl/wildmat_list_matcher.sv
`timescale 1ns / 1ps

// Wildmat list matcher. Words arrive with a command in tuser: clear the
// pattern, append a pattern byte, a text byte, or end of text; only end of
// text returns a word, carrying matched (bit 0) and pattern_overflow (bit 1)
// in the cycle after it is taken. Clear and append words are taken every cycle.
// Each pattern change starts a compile pass in which a token walks the row of
// PATTERN_BYTES+1 cells, one cell per cycle, giving each byte its role;
// text and end words wait until that pass has finished after the last
// pattern change. After that, text bytes are taken one per cycle: every
// cell holds one pattern position, and its live bit, the class-hit chain
// and the star closure ripple along the row combinationally.
// An end word also waits while an earlier result has not been taken.
module wildmat_list_matcher #(
    parameter int unsigned PATTERN_BYTES = 32
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       s_axis_tvalid,
    output logic       s_axis_tready,
    input  logic [7:0] s_axis_tdata,   // [7:0] data_byte
    input  logic [1:0] s_axis_tuser,   // [1:0] cmd
    output logic       m_axis_tvalid,
    input  logic       m_axis_tready,
    output logic [7:0] m_axis_tdata    // [0] matched, [1] pattern_overflow, [7:2] zero
);
    import wlm_pkg::*;

    localparam int unsigned NPOS = PATTERN_BYTES + 1;
    localparam int unsigned LW   = $clog2(PATTERN_BYTES + 1);
    localparam int unsigned CW   = $clog2(PATTERN_BYTES + 3);
    localparam logic [LW-1:0] LEN_FULL  = LW'(PATTERN_BYTES);
    localparam logic [CW-1:0] SCAN_CYCS = CW'(PATTERN_BYTES + 2);

    logic [LW-1:0] r_len;
    logic          r_ovf;
    logic          r_open;
    logic          r_need;
    logic [CW-1:0] r_cnt;
    logic          r_ovalid;
    logic          r_matched;
    logic          r_povf;

    t_cmd  w_cmd;
    logic  w_acc;
    logic  w_pchg;
    logic  w_inject;
    logic  w_compiled;
    logic  w_res;
    t_ctl  w_ctl;

    logic [BYTE_W-1:0] w_pat   [NPOS+2];
    logic              w_valid [NPOS+2];
    logic              w_below [NPOS];
    t_scan             w_scan  [NPOS+1];
    t_link             w_link  [NPOS+1];
    logic              w_cur   [NPOS];
    logic              w_end   [NPOS];
    logic              w_neg   [NPOS];

    assign w_cmd = t_cmd'(s_axis_tuser);

    // Pattern words always go; text waits for a finished compile; an end
    // word also needs room in the output register.
    assign w_compiled = !r_need && (r_cnt == '0);
    always_comb begin
        case (w_cmd)
            CMD_CLEAR, CMD_APPEND: s_axis_tready = 1'b1;
            CMD_TEXT:              s_axis_tready = w_compiled;
            CMD_END:               s_axis_tready = w_compiled &&
                                                   (!r_ovalid || m_axis_tready);
            default:               s_axis_tready = 1'b0;
        endcase
    end

    assign w_acc    = s_axis_tvalid && s_axis_tready;
    assign w_pchg   = w_acc && (w_cmd == CMD_CLEAR || w_cmd == CMD_APPEND);
    // hold the compile start while a pattern word is being taken
    assign w_inject = r_need && !w_pchg;

    assign w_ctl.open = r_open;
    assign w_ctl.upd  = w_acc && (w_cmd == CMD_TEXT);
    assign w_ctl.clr  = w_acc && (w_cmd != CMD_TEXT);
    assign w_ctl.c    = s_axis_tdata;

    assign w_scan[0] = '{tok: w_inject, st: S_ITEM, ineg: 1'b0, cneg: 1'b0, pstart: 1'b0};
    assign w_link[0] = '0;

    // Neighbor taps past the last cell read as empty.
    assign w_pat[NPOS]     = '0;
    assign w_pat[NPOS+1]   = '0;
    assign w_valid[NPOS]   = 1'b0;
    assign w_valid[NPOS+1] = 1'b0;

    genvar k;
    generate
        for (k = 0; k < NPOS; k++) begin : g_cell
            logic w_we;
            assign w_below[k] = (LW'(k) < r_len);
            assign w_we = (k < PATTERN_BYTES) && w_acc && (w_cmd == CMD_APPEND) &&
                          (r_len == LW'(k));
            assign w_valid[k] = w_below[k] && (w_pat[k] != C_COMMA);

            wlm_cell u_cell (
                .i_clk       (i_clk),
                .i_rst_n     (i_rst_n),
                .i_pat_we    (w_we),
                .i_pat_wdata (s_axis_tdata),
                .i_below     (w_below[k]),
                .i_p1        (w_pat[k+1]),
                .i_p2        (w_pat[k+2]),
                .i_v1        (w_valid[k+1]),
                .i_v2        (w_valid[k+2]),
                .i_scan      (w_scan[k]),
                .o_scan      (w_scan[k+1]),
                .i_link      (w_link[k]),
                .o_link      (w_link[k+1]),
                .i_ctl       (w_ctl),
                .o_cur       (w_cur[k]),
                .o_end       (w_end[k]),
                .o_neg       (w_neg[k])
            );
            assign w_pat[k] = u_cell.r_pat;
        end
    endgenerate

    // The last live item end decides; a leading bang inverts that item.
    always_comb begin
        logic found;
        found = 1'b0;
        w_res = 1'b0;
        for (int i = NPOS - 1; i >= 0; i--) begin
            if (!found && w_cur[i] && w_end[i]) begin
                w_res = !w_neg[i];
                found = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len    <= '0;
            r_ovf    <= 1'b0;
            r_open   <= 1'b0;
            r_need   <= 1'b1;
            r_cnt    <= '0;
            r_ovalid <= 1'b0;
        end else begin
            if (w_acc) begin
                case (w_cmd)
                    CMD_CLEAR: begin
                        r_len  <= '0;
                        r_ovf  <= 1'b0;
                        r_open <= 1'b0;
                    end
                    CMD_APPEND: begin
                        if (r_len == LEN_FULL) begin
                            r_ovf <= 1'b1;
                        end else begin
                            r_len <= r_len + 1'b1;
                        end
                        r_open <= 1'b0;
                    end
                    CMD_TEXT: r_open <= 1'b1;
                    default:  r_open <= 1'b0;
                endcase
            end

            if (w_pchg) begin
                r_need <= 1'b1;
            end else if (w_inject) begin
                r_need <= 1'b0;
            end

            if (w_inject) begin
                r_cnt <= SCAN_CYCS;
            end else if (r_cnt != '0) begin
                r_cnt <= r_cnt - 1'b1;
            end

            if (w_acc && w_cmd == CMD_END) begin
                r_ovalid <= 1'b1;
            end else if (m_axis_tready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_acc && w_cmd == CMD_END) begin
            r_matched <= (r_len == '0) || w_res;
            r_povf    <= r_ovf;
        end
    end

    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = {6'b0, r_povf, r_matched};

endmodule

>>> hdl/wlm_checker.sv
`timescale 1ns / 1ps

`include "wildmat_list_matcher_assert.svh"

module wlm_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       s_axis_tvalid,
    input logic       s_axis_tready,
    input logic [7:0] s_axis_tdata,
    input logic [1:0] s_axis_tuser,
    input logic       m_axis_tvalid,
    input logic       m_axis_tready,
    input logic [7:0] m_axis_tdata
);
    import wlm_pkg::*;

    logic w_end_acc;
    logic w_pat_word;

    assign w_end_acc  = s_axis_tvalid && s_axis_tready && (s_axis_tuser == CMD_END);
    assign w_pat_word = (s_axis_tuser == CMD_CLEAR) || (s_axis_tuser == CMD_APPEND);

    `WLM_ASSERT_NEXT(a_end_gives_word, w_end_acc, m_axis_tvalid)
    `WLM_ASSERT_NOW(a_word_from_end, $rose(m_axis_tvalid), $past(w_end_acc))
    `WLM_ASSERT_NOW(a_pattern_never_stalls, s_axis_tvalid && w_pat_word, s_axis_tready)
    `WLM_ASSERT_NEXT(a_out_holds, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata))

endmodule

bind wildmat_list_matcher wlm_checker u_wlm_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);
